// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) else $error(msg);

`endif

// ----- hw/rtl/bst_pkg.sv -----
// Shared types and constants of the byte stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    // Default widths of the result fields
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int OFFSET_WIDTH_DEF = 16;
    localparam int LENGTH_WIDTH_DEF = 8;

    // Result queue depth (power of two, at least 2)
    localparam int FIFO_DEPTH_DEF = 4;

    // Token kinds
    typedef enum logic [3:0] {
        KIND_LET     = 4'd0,
        KIND_PRINT   = 4'd1,
        KIND_IDENT   = 4'd2,
        KIND_NUMBER  = 4'd3,
        KIND_EQUALS  = 4'd4,
        KIND_PLUS    = 4'd5,
        KIND_MINUS   = 4'd6,
        KIND_STAR    = 4'd7,
        KIND_SLASH   = 4'd8,
        KIND_LPAREN  = 4'd9,
        KIND_RPAREN  = 4'd10,
        KIND_SEMI    = 4'd11,
        KIND_UNKNOWN = 4'd12
    } kind_t;

    // Scanner state, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WORD = 3'b010,
        MODE_NUM  = 3'b100
    } mode_t;

    // Punctuation bytes
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    // Keyword spellings: "let" and "print"
    localparam int KW_LET_LEN   = 3;
    localparam int KW_PRINT_LEN = 5;
    localparam logic [7:0] KW_LET [0:3] = '{8'h6C, 8'h65, 8'h74, 8'h00};
    localparam logic [7:0] KW_PRINT [0:7] =
        '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00};

endpackage

`default_nettype wire

// ----- hw/rtl/bst_fifo.sv -----
// Result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push0,
    input  wire logic [WIDTH-1:0] data0,
    input  wire logic             push1,
    input  wire logic [WIDTH-1:0] data1,
    output logic                  room2,
    output logic                  out_valid,
    output logic      [WIDTH-1:0] out_data,
    input  wire logic             out_ready
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign room2     = (count_reg <= (AW+1)'(DEPTH - 2));

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push0) + AW'(push1);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push0) + (AW+1)'(push1) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push0) begin
            mem_reg[wr_ptr_reg] <= data0;
        end
        if (push1) begin
            mem_reg[wr_ptr_reg + AW'(1)] <= data1;
        end
    end

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg <= (AW+1)'(DEPTH), "queue overfilled")
    `ASSERT_CLK(a_push_order, aclk, aresetn, push1 |-> push0, "second push without first")
    `ASSERT_CLK(a_push_room, aclk, aresetn, push0 |-> room2, "push without room")

endmodule

`default_nettype wire

// ----- hw/rtl/byte_stream_tokenizer_top.sv -----
// Top level of the byte stream tokenizer: input stage, scanner and result queue.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_valid / s_ready  | char_byte, is_last
//  m_      | out | m_valid / m_ready  | token_kind, start_offset, token_length,
//          |     |                    | token_value, unknown_char, overflow,
//          |     |                    | last_of_run, end_of_text
//
// One byte is accepted per cycle unless a stalled byte waits in the input register; the
// scanner decides a byte from the input register and pushes 0 to 2 tokens into the queue.
// A byte waits in the input register while the queue has fewer than two free slots.
// A byte's first token reaches m_ through the input register and the result queue.
// Synchronous active-low reset clears scanner state, offset counter and queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module byte_stream_tokenizer_top
    import bst_pkg::*;
#(
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
    parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_char_byte,
    input  wire logic                    s_is_last,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [3:0]                   m_token_kind,
    output logic [OFFSET_WIDTH-1:0]      m_start_offset,
    output logic [LENGTH_WIDTH-1:0]      m_token_length,
    output logic [VALUE_WIDTH-1:0]       m_token_value,
    output logic [7:0]                   m_unknown_char,
    output logic                         m_overflow,
    output logic                         m_last_of_run,
    output logic                         m_end_of_text
);

    typedef struct packed {
        logic [3:0]              kind;
        logic [OFFSET_WIDTH-1:0] start;
        logic [LENGTH_WIDTH-1:0] len;
        logic [VALUE_WIDTH-1:0]  val;
        logic [7:0]              uch;
        logic                    ovf;
        logic                    lor;
        logic                    eot;
    } tok_t;

    localparam int TW = $bits(tok_t);

    // Input stage
    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       advance;
    logic       last_taken;
    logic       room2;

    // Scanner state
    mode_t                   mode_reg, mode_next, mode_u;
    logic [VALUE_WIDTH-1:0]  acc_reg, acc_next, acc_u;
    logic [LENGTH_WIDTH-1:0] len_reg, len_next, len_u;
    logic                    let_reg, let_next, let_u;
    logic                    prt_reg, prt_next, prt_u;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next, start_u;
    logic                    ovf_reg, ovf_next, ovf_u;

    // Per-byte decode
    logic                    is_al, is_dg, is_sp;
    logic                    flush_f, single_s, flush_l;
    logic [VALUE_WIDTH+3:0]  prod;
    tok_t                    tok_f, tok_s, tok_l, slot0, slot1;
    logic                    push0, push1;
    tok_t                    q_tok;
    logic [TW-1:0]           q_data;

    assign advance    = in_vld_reg && room2;
    assign last_taken = advance && in_last_reg;
    assign s_ready    = !in_vld_reg || room2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_byte;
            in_last_reg <= s_is_last;
        end
    end

    // Character classes
    always_comb begin
        is_al = (in_char_reg >= 8'h61 && in_char_reg <= 8'h7A) ||
                (in_char_reg >= 8'h41 && in_char_reg <= 8'h5A);
        is_dg = (in_char_reg >= 8'h30 && in_char_reg <= 8'h39);
        is_sp = (in_char_reg == 8'h20) || (in_char_reg >= 8'h09 && in_char_reg <= 8'h0D);
    end

    // Token ended by this byte, built from the pending state
    always_comb begin
        flush_f = (mode_reg == MODE_WORD && !(is_al || is_dg)) ||
                  (mode_reg == MODE_NUM && !is_dg);
        tok_f = '0;
        if (mode_reg == MODE_NUM) begin
            tok_f.kind = KIND_NUMBER;
            tok_f.val  = acc_reg;
        end else if (let_reg && len_reg == LENGTH_WIDTH'(KW_LET_LEN)) begin
            tok_f.kind = KIND_LET;
        end else if (prt_reg && len_reg == LENGTH_WIDTH'(KW_PRINT_LEN)) begin
            tok_f.kind = KIND_PRINT;
        end else begin
            tok_f.kind = KIND_IDENT;
        end
        tok_f.start = start_reg;
        tok_f.len   = len_reg;
        tok_f.ovf   = ovf_reg;
    end

    // Scanner update for this byte
    always_comb begin
        mode_u   = flush_f ? MODE_IDLE : mode_reg;
        acc_u    = acc_reg;
        len_u    = len_reg;
        let_u    = let_reg;
        prt_u    = prt_reg;
        start_u  = start_reg;
        ovf_u    = ovf_reg;
        single_s = 1'b0;
        prod     = '0;
        tok_s    = '0;

        // open a word or a number
        if (mode_u == MODE_IDLE && (is_al || is_dg)) begin
            mode_u  = is_al ? MODE_WORD : MODE_NUM;
            start_u = pos_reg;
            len_u   = '0;
            acc_u   = '0;
            let_u   = 1'b1;
            prt_u   = 1'b1;
            ovf_u   = 1'b0;
        end

        if (mode_u == MODE_WORD) begin
            let_u = let_u && (len_u < LENGTH_WIDTH'(KW_LET_LEN)) &&
                    (in_char_reg == KW_LET[len_u[1:0]]);
            prt_u = prt_u && (len_u < LENGTH_WIDTH'(KW_PRINT_LEN)) &&
                    (in_char_reg == KW_PRINT[len_u[2:0]]);
        end else if (mode_u == MODE_NUM) begin
            // acc * 10 + digit, saturating
            prod = ({4'b0, acc_u} << 3) + ({4'b0, acc_u} << 1) +
                   (VALUE_WIDTH+4)'(in_char_reg - 8'h30);
            if (|prod[VALUE_WIDTH+3:VALUE_WIDTH]) begin
                acc_u = '1;
                ovf_u = 1'b1;
            end else begin
                acc_u = prod[VALUE_WIDTH-1:0];
            end
        end else if (!is_sp) begin
            single_s    = 1'b1;
            tok_s.start = pos_reg;
            tok_s.len   = LENGTH_WIDTH'(1);
            case (in_char_reg)
                CH_EQ:     tok_s.kind = KIND_EQUALS;
                CH_PLUS:   tok_s.kind = KIND_PLUS;
                CH_MINUS:  tok_s.kind = KIND_MINUS;
                CH_STAR:   tok_s.kind = KIND_STAR;
                CH_SLASH:  tok_s.kind = KIND_SLASH;
                CH_LPAREN: tok_s.kind = KIND_LPAREN;
                CH_RPAREN: tok_s.kind = KIND_RPAREN;
                CH_SEMI:   tok_s.kind = KIND_SEMI;
                default: begin
                    tok_s.kind = KIND_UNKNOWN;
                    tok_s.uch  = in_char_reg;
                end
            endcase
        end

        // length grows, sticking at full scale
        if (mode_u != MODE_IDLE) begin
            if (len_u == '1) begin
                ovf_u = 1'b1;
            end else begin
                len_u = len_u + LENGTH_WIDTH'(1);
            end
        end
    end

    // Token flushed by a last byte, built from the updated state
    always_comb begin
        flush_l = in_last_reg && (mode_u != MODE_IDLE);
        tok_l   = '0;
        if (mode_u == MODE_NUM) begin
            tok_l.kind = KIND_NUMBER;
            tok_l.val  = acc_u;
        end else if (let_u && len_u == LENGTH_WIDTH'(KW_LET_LEN)) begin
            tok_l.kind = KIND_LET;
        end else if (prt_u && len_u == LENGTH_WIDTH'(KW_PRINT_LEN)) begin
            tok_l.kind = KIND_PRINT;
        end else begin
            tok_l.kind = KIND_IDENT;
        end
        tok_l.start = start_u;
        tok_l.len   = len_u;
        tok_l.ovf   = ovf_u;
    end

    // Order tokens into the two queue slots and mark the final one
    always_comb begin
        slot0 = flush_f ? tok_f : (single_s ? tok_s : tok_l);
        slot1 = single_s ? tok_s : tok_l;
        push0 = advance && (flush_f || single_s || flush_l);
        push1 = advance && flush_f && (single_s || flush_l);
        if (push1) begin
            slot1.lor = 1'b1;
            slot1.eot = in_last_reg;
        end else begin
            slot0.lor = 1'b1;
            slot0.eot = in_last_reg;
        end
    end

    // Next scanner state
    always_comb begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        let_next   = let_reg;
        prt_next   = prt_reg;
        start_next = start_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        if (advance) begin
            mode_next  = in_last_reg ? MODE_IDLE : mode_u;
            acc_next   = acc_u;
            len_next   = len_u;
            let_next   = let_u;
            prt_next   = prt_u;
            start_next = start_u;
            ovf_next   = ovf_u;
            pos_next   = in_last_reg ? '0 : pos_reg + OFFSET_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            len_reg   <= '0;
            let_reg   <= 1'b0;
            prt_reg   <= 1'b0;
            pos_reg   <= '0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            let_reg   <= let_next;
            prt_reg   <= prt_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Result queue
    bst_fifo #(
        .WIDTH (TW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (push0),
        .data0     (slot0),
        .push1     (push1),
        .data1     (slot1),
        .room2     (room2),
        .out_valid (m_valid),
        .out_data  (q_data),
        .out_ready (m_ready)
    );

    assign q_tok          = q_data;
    assign m_token_kind   = q_tok.kind;
    assign m_start_offset = q_tok.start;
    assign m_token_length = q_tok.len;
    assign m_token_value  = q_tok.val;
    assign m_unknown_char = q_tok.uch;
    assign m_overflow     = q_tok.ovf;
    assign m_last_of_run  = q_tok.lor;
    assign m_end_of_text  = q_tok.eot;

    `ASSERT_CLK(a_stall_holds, aclk, aresetn, !s_ready |=> in_vld_reg, "stalled request lost")
    `ASSERT_CLK(a_pos_reset, aclk, aresetn, last_taken |=> pos_reg == '0, "offset not cleared")
    `ASSERT_CLK(a_idle_after_last, aclk, aresetn, last_taken |=> mode_reg == MODE_IDLE, "busy")

endmodule

`default_nettype wire
